/* design/sto_pkg.sv */
// Shared widths and register indexes for the strided tensor offset block.
`timescale 1ns / 1ps
package sto_pkg;

  localparam int EXT_W = 16;   // extent width
  localparam int OFF_W = 32;   // stride, offset and data width
  localparam int RANK_W = 2;
  localparam int REG_W = 3;    // config index width

  typedef enum logic [REG_W-1:0] {
    REG_RANK    = 3'd0,
    REG_SIZE0   = 3'd1,
    REG_SIZE1   = 3'd2,
    REG_SIZE2   = 3'd3,
    REG_STRIDE0 = 3'd4,
    REG_STRIDE1 = 3'd5,
    REG_STRIDE2 = 3'd6,
    REG_BASE    = 3'd7
  } cfg_reg_t;

endpackage

/* design/sto_dim_unit.sv */
// One tensor dimension: pipelined divide by extent, multiply by stride, accumulate.
`timescale 1ns / 1ps
module sto_dim_unit
  import sto_pkg::*;
#(
  parameter int IW = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             active,
  input  logic [EXT_W-1:0] ext,
  input  logic [OFF_W-1:0] stride,
  input  logic             i_vld,
  input  logic [IW-1:0]    i_rest,
  input  logic [OFF_W-1:0] i_acc,
  output logic             o_vld,
  output logic [IW-1:0]    o_rest,
  output logic [OFF_W-1:0] o_acc
);

  localparam int SB = 4;                 // quotient bits per stage
  localparam int NS = (IW + SB - 1) / SB;
  localparam int PW = NS * SB;

  // Skip the divide when the dimension is unused or has zero extent:
  // the dividend then stays put, and comes out as the part for zero extent.
  logic hold;
  assign hold = !active || (ext == '0);

  logic             d_vld [0:NS];
  logic [EXT_W-1:0] d_rem [0:NS];
  logic [PW-1:0]    d_num [0:NS];
  logic [OFF_W-1:0] d_acc [0:NS];

  assign d_vld[0] = i_vld;
  assign d_rem[0] = '0;
  assign d_num[0] = PW'(i_rest);
  assign d_acc[0] = i_acc;

  for (genvar s = 0; s < NS; s++) begin : g_div
    logic [EXT_W-1:0] rem_next;
    logic [PW-1:0]    num_next;

    always_comb begin : p_step
      logic [EXT_W:0] t;
      logic [EXT_W-1:0] r;
      logic [PW-1:0] n;
      r = d_rem[s];
      n = d_num[s];
      t = '0;
      for (int j = 0; j < SB; j++) begin
        if (!hold) begin
          t = {r, n[PW-1]};
          n = n << 1;
          if (t >= {1'b0, ext}) begin
            t = t - {1'b0, ext};
            n[0] = 1'b1;
          end
          r = t[EXT_W-1:0];
        end
      end
      rem_next = r;
      num_next = n;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        d_vld[s+1] <= 1'b0;
      end else if (en) begin
        d_vld[s+1] <= d_vld[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        d_rem[s+1] <= rem_next;
        d_num[s+1] <= num_next;
        d_acc[s+1] <= d_acc[s];
      end
    end
  end

  // Multiply stage
  logic [OFF_W-1:0] part;
  logic             m_vld;
  logic [IW-1:0]    m_rest;
  logic [OFF_W-1:0] m_prod;
  logic [OFF_W-1:0] m_acc;

  always_comb begin
    if (!active) begin
      part = '0;
    end else if (ext == '0) begin
      part = OFF_W'(d_num[NS][IW-1:0]);
    end else begin
      part = OFF_W'(d_rem[NS]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_vld <= 1'b0;
    end else if (en) begin
      m_vld <= d_vld[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_rest <= (active && ext == '0) ? '0 : d_num[NS][IW-1:0];
      m_prod <= OFF_W'(part * stride);
      m_acc  <= d_acc[NS];
    end
  end

  // Accumulate stage
  always_ff @(posedge clk) begin
    if (rst) begin
      o_vld <= 1'b0;
    end else if (en) begin
      o_vld <= m_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_rest <= m_rest;
      o_acc  <= m_acc + m_prod;
    end
  end

`ifndef NO_ASSERTIONS
  a_rem_below_ext: assert property (@(posedge clk) disable iff (rst)
    (d_vld[NS] && !hold) |-> (d_rem[NS] < ext))
    else $error("remainder not below extent");

  a_zero_ext_rest: assert property (@(posedge clk) disable iff (rst)
    (o_vld && active && ext == '0) |-> (o_rest == '0))
    else $error("zero extent left a nonzero rest");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!o_vld && !m_vld))
    else $error("valid survived reset");
`endif

endmodule

/* design/strided_tensor_offset.sv */
// Top level: config registers and a chain of dimension units mapping index to offset.
// Each dimension unit is a restoring divider, four quotient bits per stage,
//   followed by multiply and add stages.
// Throughput: one item per cycle; the whole pipeline advances together and holds on a stall.
// Reset (rst, synchronous): clears all valid bits, rank 1, extents 1, strides 1, base 0.
// Config writes are always taken; they must arrive only while the pipeline is empty.
`timescale 1ns / 1ps
module strided_tensor_offset
  import sto_pkg::*;
#(
  parameter int MAX_DIMS   = 3,
  parameter int INDEX_BITS = 32
) (
  input  logic             clk,
  input  logic             rst,
  // input items
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [31:0]      s_tdata,    // [31:0] element_number
  // result items
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [31:0]      m_tdata,    // [31:0] element_offset
  // config writes
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [REG_W-1:0] cfg_index,
  input  logic [31:0]      cfg_data
);

  // Index bits that survive the input truncation
  localparam int IW = (INDEX_BITS < OFF_W) ? INDEX_BITS : OFF_W;

  logic [RANK_W-1:0] rank;
  logic [EXT_W-1:0]  size   [0:2];
  logic [OFF_W-1:0]  stride [0:2];
  logic [OFF_W-1:0]  base;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rank <= RANK_W'(1);
      for (int d = 0; d < 3; d++) begin
        size[d]   <= EXT_W'(1);
        stride[d] <= OFF_W'(1);
      end
      base <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_RANK:    rank      <= cfg_data[RANK_W-1:0];
        REG_SIZE0:   size[0]   <= cfg_data[EXT_W-1:0];
        REG_SIZE1:   size[1]   <= cfg_data[EXT_W-1:0];
        REG_SIZE2:   size[2]   <= cfg_data[EXT_W-1:0];
        REG_STRIDE0: stride[0] <= cfg_data;
        REG_STRIDE1: stride[1] <= cfg_data;
        REG_STRIDE2: stride[2] <= cfg_data;
        REG_BASE:    base      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Whole pipeline moves when the output register is free or being drained.
  logic en;
  assign en = !m_tvalid || m_tready;
  assign s_tready = en;

  // Chain position k handles dimension MAX_DIMS-1-k: innermost first.
  // A dimension at or above the rank passes rest and sum untouched, which
  // also saturates a rank above MAX_DIMS.
  logic            c_vld  [0:MAX_DIMS];
  logic [IW-1:0]   c_rest [0:MAX_DIMS];
  logic [OFF_W-1:0] c_acc [0:MAX_DIMS];

  assign c_vld[0]  = s_tvalid && s_tready;
  assign c_rest[0] = s_tdata[IW-1:0];
  assign c_acc[0]  = base;

  for (genvar k = 0; k < MAX_DIMS; k++) begin : g_dim
    localparam int D = MAX_DIMS - 1 - k;
    logic act;
    assign act = (RANK_W'(D) < rank);

    sto_dim_unit #(.IW(IW)) u_dim (
      .clk    (clk),
      .rst    (rst),
      .en     (en),
      .active (act),
      .ext    (size[D]),
      .stride (stride[D]),
      .i_vld  (c_vld[k]),
      .i_rest (c_rest[k]),
      .i_acc  (c_acc[k]),
      .o_vld  (c_vld[k+1]),
      .o_rest (c_rest[k+1]),
      .o_acc  (c_acc[k+1])
    );
  end

  // Last unit's add stage is the output register.
  assign m_tvalid = c_vld[MAX_DIMS];
  assign m_tdata  = c_acc[MAX_DIMS];

endmodule
